### rtl/lsc_pkg.sv
// Shared constants for the line-scan track center and steering block.
// No dependencies; imported by line_scan_track_center_steering.
package lsc_pkg;

  localparam int LINE_LENGTH_DEF = 128;

  // window and steering map limits
  localparam int RUN_SPAN    = 2;
  localparam int CENTER_LOW  = 33;
  localparam int CENTER_HIGH = 96;
  localparam int MAP_SPAN    = CENTER_HIGH - CENTER_LOW;

  // x / 63 as (x * RECIP) >> RECIP_SHIFT, low by at most one for x < 2**22
  localparam int RECIP       = 4161;
  localparam int RECIP_SHIFT = 18;
  localparam int PROD_W      = 22;

  localparam logic [15:0] THRESHOLD_RST  = 16'd32768;
  localparam logic [15:0] LEFT_CODE_RST  = 16'd16384;
  localparam logic [15:0] RIGHT_CODE_RST = 16'd49152;

  localparam int ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_THRESHOLD  = 2'd0,
    REG_LEFT_CODE  = 2'd1,
    REG_RIGHT_CODE = 2'd2,
    REG_NONE       = 2'd3
  } reg_index_t;

endpackage

### rtl/line_scan_track_center_steering.sv
// Line-scan edge search, track center and servo steering map.
// Depends on lsc_pkg (limits, reciprocal constant, register map).
//
//  channel | direction | handshake           | word
//  --------+-----------+---------------------+------------------------------------
//  input   | in        | in_valid / in_stall | pixel, last_pixel
//  output  | out       | out_valid/out_stall | center, steering, right_found,
//          |           |                     | left_found
//  config  | in        | APB psel/penable    | line_threshold, left/right codes
//
// One pixel is taken every cycle unless in_stall is high; the edge search
// updates at the accepting edge. A marked pixel enters a five-register result
// pipeline (capture, center, product, reciprocal multiply, output), and its
// result moves through these registers in that order.
// Reset clears the scan state and the pipeline valid bits and loads the
// register reset values.
// A stalled output backs up the pipeline; the input stalls only when all five
// result registers are full.
module line_scan_track_center_steering
  import lsc_pkg::*;
#(
  parameter int LINE_LENGTH = LINE_LENGTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [15:0]       pixel,
  input  logic              last_pixel,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [6:0]        center,
  output logic [15:0]       steering,
  output logic              right_found,
  output logic              left_found,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int IW = $clog2(LINE_LENGTH);
  localparam int EW = (IW > 7) ? IW : 7;
  localparam int MW = $clog2(MAP_SPAN + 1);

  typedef enum logic [1:0] {
    SEEK_BRIGHT,
    SEEK_DARK,
    DONE
  } phase_t;

  // ---------------- configuration ----------------
  logic [15:0] line_threshold;
  logic [15:0] left_code;
  logic [15:0] right_code;
  reg_index_t  cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      line_threshold <= THRESHOLD_RST;
      left_code      <= LEFT_CODE_RST;
      right_code     <= RIGHT_CODE_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (cfg_sel)
        REG_THRESHOLD:  line_threshold <= pwdata[15:0];
        REG_LEFT_CODE:  left_code      <= pwdata[15:0];
        REG_RIGHT_CODE: right_code     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_THRESHOLD:  prdata = {16'd0, line_threshold};
      REG_LEFT_CODE:  prdata = {16'd0, left_code};
      REG_RIGHT_CODE: prdata = {16'd0, right_code};
      default:        prdata = 32'd0;
    endcase
  end

  // ---------------- pipeline handshake ----------------
  logic v0, v1, v2, v3;
  logic rdy0, rdy1, rdy2, rdy3, rdy4;
  logic in_take;

  assign rdy4     = !out_valid || !out_stall;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign rdy0     = !v0 || rdy1;
  assign in_stall = !rdy0;
  assign in_take  = in_valid && !in_stall;

  // ---------------- edge search ----------------
  logic [15:0]   older_sample, newer_sample;
  logic [IW-1:0] pixel_index;
  logic [IW-1:0] right_edge, left_edge;
  phase_t        scan_phase;
  logic          in_window, all_above, all_below;

  assign in_window = (pixel_index >= IW'(RUN_SPAN)) &&
                     (pixel_index <= IW'(LINE_LENGTH - 2));
  assign all_above = (older_sample > line_threshold) && (newer_sample > line_threshold) &&
                     (pixel > line_threshold);
  assign all_below = (older_sample < line_threshold) && (newer_sample < line_threshold) &&
                     (pixel < line_threshold);

  // capture stage
  logic [IW-1:0] cap_right, cap_left;
  logic          cap_rf, cap_lf;

  always_ff @(posedge clk) begin
    if (rst) begin
      older_sample <= '0;
      newer_sample <= '0;
      pixel_index  <= '0;
      right_edge   <= '0;
      left_edge    <= '0;
      scan_phase   <= SEEK_BRIGHT;
      v0           <= 1'b0;
    end else begin
      if (v0 && rdy1) v0 <= 1'b0;
      if (in_take) begin
        if (last_pixel) begin
          cap_right    <= right_edge;
          cap_left     <= left_edge;
          cap_rf       <= (scan_phase != SEEK_BRIGHT);
          cap_lf       <= (scan_phase == DONE);
          v0           <= 1'b1;
          older_sample <= '0;
          newer_sample <= '0;
          pixel_index  <= '0;
          right_edge   <= '0;
          left_edge    <= '0;
          scan_phase   <= SEEK_BRIGHT;
        end else begin
          if (in_window) begin
            case (scan_phase)
              SEEK_BRIGHT: if (all_above) begin
                right_edge <= pixel_index;
                scan_phase <= SEEK_DARK;
              end
              SEEK_DARK: if (all_below) begin
                left_edge  <= pixel_index - IW'(RUN_SPAN);
                scan_phase <= DONE;
              end
              default: ;
            endcase
          end
          older_sample <= newer_sample;
          newer_sample <= pixel;
          if (pixel_index < IW'(LINE_LENGTH - 1)) pixel_index <= pixel_index + 1'b1;
        end
      end
    end
  end

  // ---------------- stage 1: center, map index ----------------
  logic signed [IW:0] diff, half;
  logic [IW-1:0]      center_calc;
  logic               lo_calc, hi_calc;

  assign diff        = $signed({1'b0, cap_left}) - $signed({1'b0, cap_right});
  // truncate toward zero: bias negative values up by one before the shift
  assign half        = (diff + $signed({{IW{1'b0}}, diff[IW]})) >>> 1;
  assign center_calc = IW'($signed({1'b0, cap_right}) + half);
  assign lo_calc     = (32'(center_calc) < CENTER_LOW);
  assign hi_calc     = (32'(center_calc) > CENTER_HIGH);

  logic [IW-1:0] c1;
  logic          lo1, hi1, neg1, rf1, lf1;
  logic [MW-1:0] m1;
  logic [15:0]   mag1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= v0;
    end
    if (rdy1 && v0) begin
      c1   <= center_calc;
      lo1  <= lo_calc;
      hi1  <= hi_calc;
      m1   <= (lo_calc || hi_calc) ? '0 : MW'(CENTER_HIGH - 32'(center_calc));
      neg1 <= (right_code < left_code);
      mag1 <= (right_code < left_code) ? (left_code - right_code)
                                        : (right_code - left_code);
      rf1  <= cap_rf;
      lf1  <= cap_lf;
    end
  end

  // ---------------- stage 2: span times map index ----------------
  logic [IW-1:0]     c2;
  logic              lo2, hi2, neg2, rf2, lf2;
  logic [PROD_W-1:0] x2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
    if (rdy2 && v1) begin
      c2   <= c1;
      lo2  <= lo1;
      hi2  <= hi1;
      neg2 <= neg1;
      rf2  <= rf1;
      lf2  <= lf1;
      x2   <= PROD_W'(mag1 * m1);
    end
  end

  // ---------------- stage 3: reciprocal multiply ----------------
  localparam int RW = $clog2(RECIP + 1);

  logic [PROD_W+RW-1:0] recip_prod;
  logic [IW-1:0]        c3;
  logic                 lo3, hi3, neg3, rf3, lf3;
  logic [PROD_W-1:0]    x3;
  logic [15:0]          q3;

  assign recip_prod = x2 * RW'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (rdy3) begin
      v3 <= v2;
    end
    if (rdy3 && v2) begin
      c3   <= c2;
      lo3  <= lo2;
      hi3  <= hi2;
      neg3 <= neg2;
      rf3  <= rf2;
      lf3  <= lf2;
      x3   <= x2;
      q3   <= 16'(recip_prod >> RECIP_SHIFT);
    end
  end

  // ---------------- stage 4: correct quotient, apply to left code, clamp, select ----------------
  logic [PROD_W-1:0]  rem3;
  logic [16:0]        q_fix;
  logic signed [18:0] val;
  logic [15:0]        steer_mid;
  logic [EW-1:0]      c_ext;

  assign rem3  = x3 - PROD_W'((q3 << 6) - q3);
  assign q_fix = {1'b0, q3} + {16'd0, (rem3 >= PROD_W'(MAP_SPAN))};
  assign val   = neg3 ? ($signed({3'b000, left_code}) - $signed({2'b00, q_fix}))
                      : ($signed({3'b000, left_code}) + $signed({2'b00, q_fix}));
  assign c_ext = EW'(c3);

  always_comb begin
    if (val < 0) steer_mid = 16'd0;
    else if (val > 19'sd65535) steer_mid = 16'hFFFF;
    else steer_mid = val[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy4) begin
      out_valid <= v3;
    end
    if (rdy4 && v3) begin
      center      <= c_ext[6:0];
      steering    <= lo3 ? right_code : (hi3 ? left_code : steer_mid);
      right_found <= rf3;
      left_found  <= lf3;
    end
  end

  // ---------------- assertions ----------------
  a_right_after_window : assert property (@(posedge clk) disable iff (rst)
    (scan_phase != SEEK_BRIGHT) |-> (right_edge >= IW'(RUN_SPAN)))
    else $error("right edge below first window end");

  a_left_not_before_right : assert property (@(posedge clk) disable iff (rst)
    (scan_phase == DONE) |-> ({1'b0, left_edge} + 1'b1 >= {1'b0, right_edge}))
    else $error("left edge lies before right edge");

  a_quotient_close : assert property (@(posedge clk) disable iff (rst)
    v3 |-> (rem3 < PROD_W'(2 * MAP_SPAN)))
    else $error("reciprocal quotient off by more than one");

  a_stall_only_full : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (v0 && v1 && v2 && v3 && out_valid && out_stall))
    else $error("input stalled with room in the result pipeline");

  a_result_from_pipe : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(v3))
    else $error("result appeared without a pipeline entry");

endmodule

### bench/lsc_checker.sv
// Scoreboard for line_scan_track_center_steering: watches the pixel, result and
// register ports, predicts each line result and compares it field by field.
// Depends on lsc_pkg (register map, reset values, steering map limits).
module lsc_checker
  import lsc_pkg::*;
#(
  parameter int LINE_LENGTH = LINE_LENGTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [15:0]       pixel,
  input  logic              last_pixel,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [6:0]        center,
  input  logic [15:0]       steering,
  input  logic              right_found,
  input  logic              left_found,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                fail_count,
  output int                pending
);

  localparam int REPORT_MAX = 10;

  typedef enum logic [1:0] {
    SEEK_BRIGHT = 2'd0,
    SEEK_DARK   = 2'd1,
    SCAN_DONE   = 2'd2
  } scan_phase_t;

  typedef struct packed {
    logic [6:0]  center;
    logic [15:0] steering;
    logic        right_found;
    logic        left_found;
  } line_result_t;

  logic [15:0]  threshold;
  logic [15:0]  left_code;
  logic [15:0]  right_code;
  logic [15:0]  prev2_px;
  logic [15:0]  prev1_px;
  int           px_index;
  int           right_pos;
  int           left_pos;
  scan_phase_t  phase;
  line_result_t expected_lines[$];
  int           mismatches = 0;
  int           queued = 0;

  assign fail_count = mismatches;
  assign pending    = queued;

  task automatic clear_scan();
    prev2_px  = '0;
    prev1_px  = '0;
    px_index  = 0;
    right_pos = 0;
    left_pos  = 0;
    phase     = SEEK_BRIGHT;
  endtask

  function automatic logic [15:0] steer_code(input int c);
    longint span;
    longint val;
    if (c < CENTER_LOW) return right_code;
    if (c > CENTER_HIGH) return left_code;
    span = longint'(right_code) - longint'(left_code);
    val  = longint'(left_code) + (span * longint'(CENTER_HIGH - c)) / longint'(MAP_SPAN);
    if (val < 0) val = 0;
    if (val > 65535) val = 65535;
    return val[15:0];
  endfunction

  // One accepted word: advance the edge search, or close the line on a marked pixel.
  task automatic scan_word(input logic [15:0] px, input logic lst);
    int           c;
    line_result_t res;
    if (lst) begin
      c               = (left_pos - right_pos) / 2 + right_pos;
      res.center      = c[6:0];
      res.steering    = steer_code(c);
      res.right_found = (phase != SEEK_BRIGHT);
      res.left_found  = (phase == SCAN_DONE);
      expected_lines.push_back(res);
      clear_scan();
    end else begin
      if (px_index >= RUN_SPAN && px_index <= LINE_LENGTH - 2) begin
        if (phase == SEEK_BRIGHT) begin
          if (prev2_px > threshold && prev1_px > threshold && px > threshold) begin
            right_pos = px_index;
            phase     = SEEK_DARK;
          end
        end else if (phase == SEEK_DARK) begin
          if (prev2_px < threshold && prev1_px < threshold && px < threshold) begin
            left_pos = px_index - RUN_SPAN;
            phase    = SCAN_DONE;
          end
        end
      end
      prev2_px = prev1_px;
      prev1_px = px;
      if (px_index < LINE_LENGTH - 1) px_index++;
    end
  endtask

  task automatic check_line(input logic [6:0] got_center, input logic [15:0] got_steering,
                            input logic got_right, input logic got_left);
    line_result_t want;
    if (expected_lines.size() == 0) begin
      if (mismatches < REPORT_MAX)
        $display("unexpected result word: center %0d steering %0d right %0b left %0b",
                 got_center, got_steering, got_right, got_left);
      mismatches++;
      return;
    end
    want = expected_lines.pop_front();
    if (got_center !== want.center || got_steering !== want.steering ||
        got_right !== want.right_found || got_left !== want.left_found) begin
      if (mismatches < REPORT_MAX)
        $display("result mismatch: exp center %0d steering %0d right %0b left %0b, %s",
                 want.center, want.steering, want.right_found, want.left_found,
                 $sformatf("got center %0d steering %0d right %0b left %0b",
                           got_center, got_steering, got_right, got_left));
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      threshold  = THRESHOLD_RST;
      left_code  = LEFT_CODE_RST;
      right_code = RIGHT_CODE_RST;
      clear_scan();
      expected_lines.delete();
    end else begin
      if (in_valid && !in_stall) scan_word(pixel, last_pixel);
      if (out_valid && !out_stall) check_line(center, steering, right_found, left_found);
      // register write lands after any word taken at the same edge
      if (psel && penable && pwrite && pready) begin
        case (reg_index_t'(paddr[3:2]))
          REG_THRESHOLD:  threshold  = pwdata[15:0];
          REG_LEFT_CODE:  left_code  = pwdata[15:0];
          REG_RIGHT_CODE: right_code = pwdata[15:0];
          default: ;
        endcase
      end
    end
    queued = expected_lines.size();
  end

endmodule

### bench/tb_top.sv
// Top of the line_scan_track_center_steering bench: clock, reset, pixel stimulus,
// register programming, output stall pacing and the verdict.
// Depends on lsc_pkg, the block under test and lsc_checker.
module tb_top;
  import lsc_pkg::*;

  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 190;
  localparam int SETTLE_CYCLES  = 10;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef enum int {
    LINE_TRACK,
    LINE_LATE,
    LINE_NOISE
  } line_style_t;

  // {last_pixel, pixel}
  localparam logic [16:0] DIRECTED [24] = '{
    17'h1FFFF,
    17'h0FFFF, 17'h10000,
    17'h0FFFF, 17'h0FFFF, 17'h0FFFF, 17'h00000, 17'h00000, 17'h00000, 17'h10000,
    17'h08000, 17'h08000, 17'h08000, 17'h08001, 17'h08001, 17'h08001,
    17'h07FFF, 17'h07FFF, 17'h07FFF, 17'h18000,
    17'h09C40, 17'h09C40, 17'h09C40, 17'h10000
  };

  logic              clk        = 1'b0;
  logic              rst        = 1'b1;
  logic              in_valid   = 1'b0;
  logic              in_stall;
  logic [15:0]       pixel      = '0;
  logic              last_pixel = 1'b0;
  logic              out_valid;
  logic              out_stall  = 1'b0;
  logic [6:0]        center;
  logic [15:0]       steering;
  logic              right_found;
  logic              left_found;
  logic              psel       = 1'b0;
  logic              penable    = 1'b0;
  logic              pwrite     = 1'b0;
  logic [ADDR_W-1:0] paddr      = '0;
  logic [31:0]       pwdata     = '0;
  logic [31:0]       prdata;
  logic              pready;

  int          fail_count;
  int          pending;
  int          items_sent    = 0;
  int          idle_cycles   = 0;
  int          stall_hold    = 0;
  logic        sender_burst  = 1'b0;
  logic [15:0] cur_threshold = THRESHOLD_RST;

  always #6 clk = ~clk;

  line_scan_track_center_steering u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .pixel(pixel), .last_pixel(last_pixel),
    .out_valid(out_valid), .out_stall(out_stall), .center(center), .steering(steering),
    .right_found(right_found), .left_found(left_found),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  lsc_checker u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .pixel(pixel), .last_pixel(last_pixel),
    .out_valid(out_valid), .out_stall(out_stall), .center(center), .steering(steering),
    .right_found(right_found), .left_found(left_found),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .pready(pready), .fail_count(fail_count), .pending(pending)
  );

  // Receiver pacing: short stalls, occasional long ones, and stall-free stretches.
  always @(negedge clk) begin : rx_pace
    int roll;
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        out_stall  <= 1'b0;
        stall_hold <= $urandom_range(0, 6);
      end else if (roll < 63) begin
        out_stall  <= 1'b0;
        stall_hold <= $urandom_range(30, 120);
      end else if (roll < 95) begin
        out_stall  <= 1'b1;
        stall_hold <= $urandom_range(0, 3);
      end else begin
        out_stall  <= 1'b1;
        stall_hold <= $urandom_range(15, 60);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("** line_scan_track_center_steering: FAILED **");
        $finish;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic push_pixel(input logic [15:0] px, input logic lst);
    int gap;
    int roll;
    roll = $urandom_range(0, 99);
    if (sender_burst || roll < 60) gap = 0;
    else if (roll < 90) gap = $urandom_range(1, 3);
    else if (roll < 98) gap = $urandom_range(4, 12);
    else gap = $urandom_range(20, 60);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    pixel      <= px;
    last_pixel <= lst;
    do @(posedge clk); while (in_stall);
    items_sent++;
    @(negedge clk);
  endtask

  // Hold the sender until every expected result has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic settle();
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), val};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic program_regs(input logic [15:0] thr, input logic [15:0] left_val,
                              input logic [15:0] right_val);
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_LEFT_CODE, left_val);
    write_reg(REG_RIGHT_CODE, right_val);
    cur_threshold = thr;
  endtask

  function automatic logic [15:0] above_level(input logic [15:0] thr);
    if (thr == 16'hFFFF) return 16'hFFFF;
    if ($urandom_range(0, 7) == 0) return thr + 16'd1;
    return 16'($urandom_range(65535, int'(thr) + 1));
  endfunction

  function automatic logic [15:0] below_level(input logic [15:0] thr);
    if (thr == 16'h0000) return 16'h0000;
    if ($urandom_range(0, 7) == 0) return thr - 16'd1;
    return 16'($urandom_range(int'(thr) - 1, 0));
  endfunction

  task automatic send_line(input line_style_t style);
    int          len;
    int          roll;
    int          seg_left;
    int          bright_from;
    int          bright_len;
    logic        bright_seg;
    logic [15:0] px;
    sender_burst = ($urandom_range(0, 3) == 0);
    bright_from  = $urandom_range(118, 130);
    bright_len   = $urandom_range(3, 5);
    seg_left     = 0;
    bright_seg   = 1'($urandom_range(0, 1));
    roll         = $urandom_range(0, 19);
    if (style == LINE_LATE) len = $urandom_range(128, 140);
    else if (roll == 0) len = $urandom_range(1, 3);
    else if (roll < 2) len = $urandom_range(100, 140);
    else len = $urandom_range(3, 32);
    for (int i = 0; i < len; i++) begin
      if (style == LINE_NOISE) begin
        roll = $urandom_range(0, 7);
        if (roll == 0) px = 16'h0000;
        else if (roll == 1) px = 16'hFFFF;
        else if (roll == 2) px = cur_threshold;
        else px = 16'($urandom);
      end else if (style == LINE_LATE) begin
        // bright run placed around the last tested window index
        if (i >= bright_from && i < bright_from + bright_len) px = above_level(cur_threshold);
        else px = below_level(cur_threshold);
      end else begin
        if (seg_left == 0) begin
          bright_seg = !bright_seg;
          seg_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 9);
        end
        seg_left--;
        if ($urandom_range(0, 11) == 0) px = cur_threshold;
        else if (bright_seg) px = above_level(cur_threshold);
        else px = below_level(cur_threshold);
      end
      if ($urandom_range(0, 299) == 0) drain_results();
      push_pixel(px, i == len - 1);
    end
  endtask

  initial begin
    int roll;
    int phase_end;
    line_style_t style;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset register values, edge and short-line corners
    foreach (DIRECTED[k]) push_pixel(DIRECTED[k][15:0], DIRECTED[k][16]);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: program_regs(16'd32768, 16'h0000, 16'hFFFF);
        1: program_regs(16'h0000, 16'hFFFF, 16'h0000);
        2: program_regs(16'hFFFF, 16'($urandom), 16'($urandom));
        default: program_regs(16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        roll = $urandom_range(0, 19);
        if (roll < 15) style = LINE_TRACK;
        else if (roll < 16) style = LINE_LATE;
        else style = LINE_NOISE;
        send_line(style);
      end
      settle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("** line_scan_track_center_steering: PASSED **");
    end else begin
      $display("** line_scan_track_center_steering: FAILED **");
    end
    $finish;
  end

endmodule
